// ===== src/fixed_step_tick_scheduler_defines.svh =====
// Assertion helpers for the fixed-step tick scheduler.
`ifndef FIXED_STEP_TICK_SCHEDULER_DEFINES_SVH
`define FIXED_STEP_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FSTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fixed_step_tick_scheduler: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FSTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fixed_step_tick_scheduler: check failed");

`endif

// ===== src/fsts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fsts_pkg;

  localparam int TIME_BITS  = 32;
  localparam int FRAC_BITS  = 8;
  localparam int SPEED_FRAC = 8;

  localparam int NOW_W      = 32;
  localparam int SPEED_W    = 16;
  localparam int PERIOD_W   = 24;
  localparam int CAP_W      = 8;
  localparam int BANK_W     = 48;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int ACTION_W   = 2;

  localparam int STEP_W     = PERIOD_W + FRAC_BITS;
  localparam int PROD_W     = TIME_BITS + SPEED_W;
  localparam int DIV_NUM_W  = (BANK_W > STEP_W + ALPHA_FRAC) ? BANK_W : STEP_W + ALPHA_FRAC;
  localparam int DIV_DEN_W  = (STEP_W > SPEED_W) ? STEP_W : SPEED_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

  localparam int SCALE_UP   = (FRAC_BITS > SPEED_FRAC) ? FRAC_BITS - SPEED_FRAC : 0;
  localparam int SCALE_DOWN = (FRAC_BITS < SPEED_FRAC) ? SPEED_FRAC - FRAC_BITS : 0;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PERIOD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_UPDATES = 2'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16667;
  localparam logic [CAP_W-1:0]    CAP_RESET    = 8'd6;
  localparam logic [SPEED_W-1:0]  SPEED_ONE    = SPEED_W'(1) << SPEED_FRAC;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = ALPHA_W'(1) << ALPHA_FRAC;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_END     = 2'd1,
    ACT_SPEED   = 2'd2,
    ACT_RESTART = 2'd3
  } fsts_action_e;

  typedef struct packed {
    logic [STEP_W-1:0]    step_ticks;
    logic [DIV_NUM_W-1:0] step_num;
    logic [CAP_W-1:0]     max_updates;
  } fsts_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } fsts_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } fsts_div_rsp_t;

  // elapsed * speed (Q8.8) into bank ticks, saturating
  function automatic logic [BANK_W-1:0] fsts_scale(input logic [PROD_W-1:0] prod);
    logic [63:0] wide;
    wide = 64'(prod);
    if ((wide >> (BANK_W - SCALE_UP)) != 64'd0) begin
      fsts_scale = '1;
    end else begin
      fsts_scale = BANK_W'((wide << SCALE_UP) >> SCALE_DOWN);
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/fixed_step_tick_scheduler.sv =====
// Fixed-step tick scheduler: every accepted request yields exactly one result. A request
// that needs no division (alpha is a full step) goes from accept to result without the
// divider; one that banks time, grants a step and then computes alpha makes two passes
// through the shared restoring divider. A held result adds its stall time.
// in_stall_o stays high from accept until the result is loaded into the output register.
// The divider serves the step advance (step / speed), the end-of-loop remainder and the
// interpolation alpha. Time is in ticks with 8 fraction bits, speed is Q8.8, alpha Q1.16.
`timescale 1ns / 1ps
`default_nettype none

module fixed_step_tick_scheduler (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fsts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fsts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [fsts_pkg::ACTION_W-1:0]   action_i,
  input  wire logic [fsts_pkg::NOW_W-1:0]      now_time_i,
  input  wire logic signed [fsts_pkg::SPEED_W-1:0] speed_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 update_granted_o,
  output logic [fsts_pkg::ALPHA_W-1:0]         interp_alpha_o,
  output logic [fsts_pkg::BANK_W-1:0]          local_time_o,
  output logic [fsts_pkg::CAP_W-1:0]           updates_in_loop_o
);
  import fsts_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE       = 4'd0;
  localparam logic [ST_W-1:0] S_ACC_MUL    = 4'd1;
  localparam logic [ST_W-1:0] S_ACC_ADD    = 4'd2;
  localparam logic [ST_W-1:0] S_CHECK      = 4'd3;
  localparam logic [ST_W-1:0] S_STEP_WAIT  = 4'd4;
  localparam logic [ST_W-1:0] S_MOD_WAIT   = 4'd5;
  localparam logic [ST_W-1:0] S_ALPHA      = 4'd6;
  localparam logic [ST_W-1:0] S_ALPHA_WAIT = 4'd7;
  localparam logic [ST_W-1:0] S_DONE       = 4'd8;

  fsts_cfg_t     cfg;
  fsts_div_req_t div_req;
  fsts_div_rsp_t div_rsp;

  logic [ST_W-1:0]      state_q, state_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [BANK_W-1:0]    bank_q, bank_d;
  logic [BANK_W-1:0]    sim_q, sim_d;
  logic [CAP_W-1:0]     count_q, count_d;
  logic                 open_q, open_d;
  logic [SPEED_W-1:0]   speed_q, speed_d;
  logic                 out_valid_q, out_valid_d;

  logic [ACTION_W-1:0]  act_q, act_d;
  logic [NOW_W-1:0]     now_q, now_d;
  logic [SPEED_W-1:0]   sv_q, sv_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic                 granted_q, granted_d;
  logic [ALPHA_W-1:0]   alpha_q, alpha_d;
  logic                 out_load;

  logic                 out_granted_q;
  logic [ALPHA_W-1:0]   out_alpha_q;
  logic [BANK_W-1:0]    out_time_q;
  logic [CAP_W-1:0]     out_count_q;

  logic [TIME_BITS-1:0] delta;
  logic                 delta_pos;
  logic                 bank_ge;
  logic [BANK_W-1:0]    add;
  logic [BANK_W:0]      bank_sum;

  fsts_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fsts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign delta     = TIME_BITS'(now_q) - last_q;
  assign delta_pos = (delta != '0) && !delta[TIME_BITS-1];
  assign bank_ge   = bank_q >= BANK_W'(cfg.step_ticks);
  assign add       = fsts_scale(prod_q);
  assign bank_sum  = {1'b0, bank_q} + {1'b0, add};

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    bank_d      = bank_q;
    sim_d       = sim_q;
    count_d     = count_q;
    open_d      = open_q;
    speed_d     = speed_q;
    act_d       = act_q;
    now_d       = now_q;
    sv_d        = sv_q;
    prod_d      = prod_q;
    granted_d   = granted_q;
    alpha_d     = alpha_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    div_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_i;
          now_d     = now_time_i;
          sv_d      = speed_value_i;
          granted_d = 1'b0;
          case (action_i)
            ACT_REQUEST: begin
              state_d = open_q ? S_CHECK : S_ACC_MUL;
            end
            ACT_END: begin
              count_d = '0;
              open_d  = 1'b0;
              if ((count_q >= cfg.max_updates) && bank_ge) begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NUM_W'(bank_q);
                div_req.divisor  = DIV_DEN_W'(cfg.step_ticks);
                state_d          = S_MOD_WAIT;
              end else begin
                state_d = S_ALPHA;
              end
            end
            ACT_SPEED: begin
              state_d = S_ACC_MUL;
            end
            ACT_RESTART: begin
              last_d  = TIME_BITS'(now_time_i);
              sim_d   = BANK_W'(TIME_BITS'(now_time_i)) << FRAC_BITS;
              bank_d  = '0;
              count_d = '0;
              open_d  = 1'b0;
              state_d = S_ALPHA;
            end
            default: ;
          endcase
        end
      end
      S_ACC_MUL: begin
        prod_d  = delta_pos ? PROD_W'(delta) * PROD_W'(speed_q) : '0;
        last_d  = TIME_BITS'(now_q);
        state_d = S_ACC_ADD;
      end
      S_ACC_ADD: begin
        bank_d = bank_sum[BANK_W] ? '1 : bank_sum[BANK_W-1:0];
        if (act_q == ACT_REQUEST) begin
          open_d  = 1'b1;
          state_d = S_CHECK;
        end else begin
          // negative speed freezes
          speed_d = sv_q[SPEED_W-1] ? '0 : sv_q;
          state_d = S_ALPHA;
        end
      end
      S_CHECK: begin
        if ((count_q < cfg.max_updates) && (speed_q != '0) && bank_ge) begin
          bank_d           = bank_q - BANK_W'(cfg.step_ticks);
          count_d          = count_q + CAP_W'(1);
          granted_d        = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = cfg.step_num;
          div_req.divisor  = DIV_DEN_W'(speed_q);
          state_d          = S_STEP_WAIT;
        end else begin
          state_d = S_ALPHA;
        end
      end
      S_STEP_WAIT: begin
        if (div_rsp.done) begin
          sim_d   = sim_q + BANK_W'(div_rsp.quotient);
          state_d = S_ALPHA;
        end
      end
      S_MOD_WAIT: begin
        if (div_rsp.done) begin
          bank_d  = BANK_W'(div_rsp.remainder);
          state_d = S_ALPHA;
        end
      end
      S_ALPHA: begin
        if (bank_ge) begin
          alpha_d = ALPHA_ONE;
          state_d = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(bank_q) << ALPHA_FRAC;
          div_req.divisor  = DIV_DEN_W'(cfg.step_ticks);
          state_d          = S_ALPHA_WAIT;
        end
      end
      S_ALPHA_WAIT: begin
        if (div_rsp.done) begin
          alpha_d = ALPHA_W'(div_rsp.quotient[ALPHA_FRAC-1:0]);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      bank_q      <= '0;
      sim_q       <= '0;
      count_q     <= '0;
      open_q      <= 1'b0;
      speed_q     <= SPEED_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      bank_q      <= bank_d;
      sim_q       <= sim_d;
      count_q     <= count_d;
      open_q      <= open_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    now_q     <= now_d;
    sv_q      <= sv_d;
    prod_q    <= prod_d;
    granted_q <= granted_d;
    alpha_q   <= alpha_d;
    if (out_load) begin
      out_granted_q <= granted_q;
      out_alpha_q   <= alpha_q;
      out_time_q    <= sim_q;
      out_count_q   <= count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign update_granted_o  = out_granted_q;
  assign interp_alpha_o    = out_alpha_q;
  assign local_time_o      = out_time_q;
  assign updates_in_loop_o = out_count_q;

endmodule

`default_nettype wire

// ===== src/fsts_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsts_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fsts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fsts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output fsts_pkg::fsts_cfg_t                  cfg_o
);
  import fsts_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic [CAP_W-1:0]    cap_q;
  logic [PERIOD_W-1:0] period_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      cap_q    <= CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_MAX_UPDATES: cap_q    <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero period counts as one
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

  assign cfg_o.step_ticks  = STEP_W'(period_eff) << FRAC_BITS;
  assign cfg_o.step_num    = DIV_NUM_W'(period_eff) << (SPEED_FRAC + FRAC_BITS);
  assign cfg_o.max_updates = cap_q;

endmodule

`default_nettype wire

// ===== src/fsts_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module fsts_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fsts_pkg::fsts_div_req_t req_i,
  output fsts_pkg::fsts_div_rsp_t rsp_o
);
  import fsts_pkg::*;

  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
      rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ===== src/fsts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_step_tick_scheduler_defines.svh"

module fsts_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         update_granted_o,
  input wire logic [fsts_pkg::ALPHA_W-1:0] interp_alpha_o,
  input wire logic [fsts_pkg::BANK_W-1:0]  local_time_o,
  input wire logic [fsts_pkg::CAP_W-1:0]   updates_in_loop_o
);
  import fsts_pkg::*;

  `FSTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `FSTS_ASSERT_NOW(a_alpha_range, out_valid_o, interp_alpha_o <= ALPHA_ONE)
  `FSTS_ASSERT_NOW(a_grant_counted, out_valid_o && update_granted_o, updates_in_loop_o != '0)
  `FSTS_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o && $stable(local_time_o) && $stable(interp_alpha_o))

endmodule

bind fixed_step_tick_scheduler fsts_checker u_fsts_checker (.*);

`default_nettype wire

// ===== tb/fixed_step_tick_scheduler_test.sv =====
`timescale 1ns / 1ps

module fixed_step_tick_scheduler_test;
  import fsts_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam logic [63:0] BANK_MAX = (64'd1 << BANK_W) - 64'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'h7FFF;
  localparam logic [SPEED_W-1:0] SPEED_MOST_NEG = 16'h8000;

  typedef struct packed {
    logic               granted;
    logic [ALPHA_W-1:0] alpha;
    logic [BANK_W-1:0]  ltime;
    logic [CAP_W-1:0]   count;
  } tick_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [ACTION_W-1:0]   action_i;
  logic [NOW_W-1:0]      now_time_i;
  logic signed [SPEED_W-1:0] speed_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  update_granted_o;
  logic [ALPHA_W-1:0]    interp_alpha_o;
  logic [BANK_W-1:0]     local_time_o;
  logic [CAP_W-1:0]      updates_in_loop_o;

  // scheduler state as predicted
  logic [PERIOD_W-1:0] cfg_period;
  logic [CAP_W-1:0]    cfg_cap;
  logic [NOW_W-1:0]    sched_last;
  logic [63:0]         sched_bank;
  logic [BANK_W-1:0]   sched_time;
  logic [CAP_W-1:0]    sched_count;
  logic                sched_open;
  logic [SPEED_W-1:0]  sched_speed;

  tick_result_t expected_ticks[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  fixed_step_tick_scheduler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .now_time_i       (now_time_i),
    .speed_value_i    (speed_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .update_granted_o (update_granted_o),
    .interp_alpha_o   (interp_alpha_o),
    .local_time_o     (local_time_o),
    .updates_in_loop_o(updates_in_loop_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void bank_elapsed(input logic [NOW_W-1:0] now);
    logic [NOW_W-1:0] elapsed;
    logic [63:0] prod;
    logic [63:0] add;
    elapsed = now - sched_last;
    if (elapsed != '0 && !elapsed[NOW_W-1]) begin
      prod = 64'(elapsed) * 64'(sched_speed);
      if (prod > (BANK_MAX >> SCALE_UP)) add = BANK_MAX;
      else add = (prod << SCALE_UP) >> SCALE_DOWN;
      sched_bank = sched_bank + add;
      if (sched_bank > BANK_MAX) sched_bank = BANK_MAX;
    end
    sched_last = now;
  endfunction

  function automatic tick_result_t predict_tick(input fsts_action_e act,
                                                input logic [NOW_W-1:0] now,
                                                input logic [SPEED_W-1:0] spd);
    logic [63:0] per;
    logic [63:0] stp;
    tick_result_t r;
    per = (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
    stp = per << FRAC_BITS;
    r.granted = 1'b0;
    case (act)
      ACT_REQUEST: begin
        if (!sched_open) begin
          bank_elapsed(now);
          sched_open = 1'b1;
        end
        if (sched_count < cfg_cap && sched_speed != '0 && sched_bank >= stp) begin
          sched_bank = sched_bank - stp;
          sched_time = sched_time +
                       BANK_W'((per << (SPEED_FRAC + FRAC_BITS)) / 64'(sched_speed));
          sched_count = sched_count + CAP_W'(1);
          r.granted = 1'b1;
        end
      end
      ACT_END: begin
        if (sched_count >= cfg_cap && sched_bank >= stp) sched_bank = sched_bank % stp;
        sched_count = '0;
        sched_open = 1'b0;
      end
      ACT_SPEED: begin
        bank_elapsed(now);
        sched_speed = spd[SPEED_W-1] ? '0 : spd;
      end
      default: begin
        sched_last = now;
        sched_time = BANK_W'(64'(now) << FRAC_BITS);
        sched_bank = '0;
        sched_count = '0;
        sched_open = 1'b0;
      end
    endcase
    r.alpha = (sched_bank >= stp) ? ALPHA_ONE : ALPHA_W'((sched_bank << ALPHA_FRAC) / stp);
    r.ltime = sched_time;
    r.count = sched_count;
    return r;
  endfunction

  function automatic void set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endfunction

  function automatic void flag_mismatch(input string what, input tick_result_t exp_r,
                                        input tick_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: exp grant=%0d alpha=%0d time=%0d count=%0d", $realtime, what,
               exp_r.granted, exp_r.alpha, exp_r.ltime, exp_r.count);
      $display("%0t: %s: got grant=%0d alpha=%0d time=%0d count=%0d", $realtime, what,
               got.granted, got.alpha, got.ltime, got.count);
    end
  endfunction

  task automatic send_request(input fsts_action_e act, input logic [NOW_W-1:0] now,
                              input logic [SPEED_W-1:0] spd);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    now_time_i <= now;
    speed_value_i <= spd;
    do @(posedge clk_i); while (in_stall_o);
    expected_ticks.push_back(predict_tick(act, now, spd));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_STEP_PERIOD) cfg_period = data;
    else if (idx == CFG_MAX_UPDATES) cfg_cap = data[CAP_W-1:0];
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    tick_result_t got;
    tick_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {update_granted_o, interp_alpha_o, local_time_o, updates_in_loop_o};
      if (expected_ticks.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        exp_r = expected_ticks.pop_front();
        if (got.granted !== exp_r.granted || got.alpha !== exp_r.alpha ||
            got.ltime !== exp_r.ltime || got.count !== exp_r.count)
          flag_mismatch("wrong result", exp_r, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [NOW_W-1:0] t;
    set_idling(0, 0);
    send_request(ACT_REQUEST, '0, '0);
    send_request(ACT_END, '0, '0);
    t = 32'd50000;
    repeat (3) send_request(ACT_REQUEST, t, '0);
    send_request(ACT_END, t, '0);
    // sample behind the last one: nothing banked
    t = 32'd40000;
    send_request(ACT_REQUEST, t, '0);
    send_request(ACT_END, t, '0);
    t = t + 32'h8000_0000;
    send_request(ACT_REQUEST, t, '0);
    send_request(ACT_END, t, '0);
    // largest forward jump: cap is hit, end keeps the remainder
    t = t + 32'h7FFF_FFFF;
    repeat (7) send_request(ACT_REQUEST, t, '0);
    send_request(ACT_END, t, '0);
    send_request(ACT_SPEED, t + 32'd1000, SPEED_MOST_NEG);
    send_request(ACT_REQUEST, t + 32'd90000, '0);
    send_request(ACT_END, t + 32'd90000, '0);
    send_request(ACT_SPEED, t + 32'd90000, 16'hFFFF);
    send_request(ACT_SPEED, t + 32'd91000, '0);
    send_request(ACT_SPEED, t + 32'd95000, SPEED_MAX);
    send_request(ACT_REQUEST, t + 32'd96000, '0);
    send_request(ACT_REQUEST, t + 32'd96000, '0);
    send_request(ACT_END, t + 32'd96000, '0);
    send_request(ACT_RESTART, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(ACT_END, 32'hFFFF_FFFF, '0);
    send_request(ACT_SPEED, 32'hFFFF_FFFF, SPEED_ONE);
  endtask

  task automatic test_register_corners();
    set_idling(84, 0);
    write_reg(CFG_STEP_PERIOD, '0);
    write_reg(CFG_MAX_UPDATES, '0);
    send_request(ACT_RESTART, 32'd0, '0);
    send_request(ACT_REQUEST, 32'd10, '0);
    send_request(ACT_REQUEST, 32'd10, '0);
    send_request(ACT_END, 32'd10, '0);
    write_reg(CFG_STEP_PERIOD, 24'd1);
    write_reg(CFG_MAX_UPDATES, 24'd1);
    send_request(ACT_REQUEST, 32'd20, '0);
    send_request(ACT_REQUEST, 32'd20, '0);
    send_request(ACT_END, 32'd20, '0);
    write_reg(CFG_SPARE_2, 24'hFFFFFF);
    write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
    send_request(ACT_REQUEST, 32'd30, '0);
    send_request(ACT_REQUEST, 32'd30, '0);
    send_request(ACT_END, 32'd30, '0);
    // upper data bits fall away for the cap
    write_reg(CFG_MAX_UPDATES, 24'hFFFFFF);
    send_request(ACT_REQUEST, 32'd2000, '0);
    send_request(ACT_END, 32'd2000, '0);
  endtask

  task automatic test_local_time_wrap();
    logic [NOW_W-1:0] t;
    set_idling(11, 11);
    write_reg(CFG_STEP_PERIOD, 24'hFFFFFF);
    write_reg(CFG_MAX_UPDATES, 24'd255);
    t = 32'hFFFF_FFFF;
    send_request(ACT_RESTART, t, '0);
    send_request(ACT_SPEED, t, SPEED_MAX);
    // bank saturates
    repeat (6) begin
      t = t + 32'h7FFF_FFFF;
      send_request(ACT_SPEED, t, SPEED_MAX);
    end
    send_request(ACT_SPEED, t, 16'd1);
    repeat (257) send_request(ACT_REQUEST, t, SPEED_W'($urandom));
    send_request(ACT_END, t, '0);
    send_request(ACT_SPEED, t, SPEED_MAX);
    t = t + 32'h7FFF_FFFF;
    send_request(ACT_SPEED, t, 16'd1);
    repeat (12) send_request(ACT_REQUEST, t, '0);
    send_request(ACT_END, t, '0);
  endtask

  task automatic test_random_frames(input int unsigned item_goal);
    logic [NOW_W-1:0] t;
    logic [SPEED_W-1:0] spd;
    int unsigned phase_goal;
    int unsigned span;
    int unsigned reqs;
    int unsigned pick;
    t = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph / 2)
        0: set_idling(0, 0);
        1: set_idling(84, 0);
        2: set_idling(0, 84);
        default: set_idling(11, 11);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_STEP_PERIOD, CFG_DATA_W'($urandom_range(1, 64)));
        1: write_reg(CFG_STEP_PERIOD, PERIOD_RESET);
        2: write_reg(CFG_STEP_PERIOD, CFG_DATA_W'($urandom_range(1000, 200000)));
        default: write_reg(CFG_STEP_PERIOD, CFG_DATA_W'($urandom));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_MAX_UPDATES, '0);
        1: write_reg(CFG_MAX_UPDATES, CFG_DATA_W'(255));
        default: write_reg(CFG_MAX_UPDATES, CFG_DATA_W'($urandom_range(1, 6)));
      endcase
      phase_goal = items_sent + item_goal / 8;
      while (items_sent < phase_goal) begin
        span = (cfg_period == '0) ? 1 : cfg_period;
        pick = $urandom_range(0, 99);
        if (pick < 3) wait_idle();
        if (pick < 10) begin
          t = $urandom;
          send_request(fsts_action_e'($urandom_range(0, 3)), t, SPEED_W'($urandom));
        end else if (pick < 14) begin
          t = $urandom;
          send_request(ACT_RESTART, t, SPEED_W'($urandom));
        end else if (pick < 24) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: spd = SPEED_ONE;
            5, 6: spd = SPEED_W'($urandom_range(1, 1024));
            7: spd = SPEED_MAX;
            8: spd = SPEED_W'($urandom_range(32'h8000, 32'hFFFF));
            default: spd = '0;
          endcase
          t = t + NOW_W'($urandom_range(0, span));
          send_request(ACT_SPEED, t, spd);
        end else begin
          if ($urandom_range(0, 19) == 0) t = t + NOW_W'($urandom);
          else t = t + NOW_W'($urandom_range(0, 4 * span));
          reqs = $urandom_range(1, (cfg_cap < 8) ? cfg_cap + 2 : 10);
          repeat (reqs) send_request(ACT_REQUEST, t, SPEED_W'($urandom));
          if ($urandom_range(0, 9) != 0) send_request(ACT_END, t, SPEED_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_STEP_PERIOD;
    cfg_data_i = '0;
    action_i = ACT_REQUEST;
    now_time_i = '0;
    speed_value_i = '0;
    cfg_period = PERIOD_RESET;
    cfg_cap = CAP_RESET;
    sched_last = '0;
    sched_bank = '0;
    sched_time = '0;
    sched_count = '0;
    sched_open = 1'b0;
    sched_speed = SPEED_ONE;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_register_corners();
    test_local_time_wrap();
    test_random_frames(800);

    wait_idle();
    repeat (150) @(posedge clk_i);
    mismatch_count += expected_ticks.size();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/fsts_pkg.sv
src/fsts_cfg.sv
src/fsts_div.sv
src/fixed_step_tick_scheduler.sv
src/fsts_checker.sv
tb/fixed_step_tick_scheduler_test.sv
